[design/assert_macros.svh]
// Assertion macros used by the design file mesh_face_normal_engine_core.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Plain check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[design/mfne_pkg.sv]
// Package: command codes and word types of the face normal engine.
`timescale 1ns / 1ps
package mfne_pkg;
  localparam logic [1:0] CMD_WRITE_POS = 2'd0;
  localparam logic [1:0] CMD_FACE      = 2'd1;
  localparam logic [1:0] CMD_READ_NRM  = 2'd2;
  localparam logic [1:0] CMD_NONE      = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic [9:0]         vertex_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [9:0]         first_corner;
    logic [9:0]         middle_corner;
    logic [9:0]         last_corner;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               degenerate;
    logic               from_face;
  } out_word_t;
endpackage

[design/mesh_face_normal_engine_core.sv]
// Mesh face normal engine: vertex memories, cross product, iterative normalizer.
// Usage: in_valid/in_ready carry one in_word_t per command. A position write
// stores a vertex and returns nothing. A face word reads its three corner
// positions (one memory read per cycle), forms the edge vectors, products and
// cross product in the steps S_DIFF, S_MUL and S_CROSS, finds the normalizing
// shift one bit a cycle, squares and sums in S_SQ, takes a restoring square
// root, then three restoring divisions (load, FB+30 steps, last bit). It
// writes the normal to the three corners, one write per cycle, and emits one
// out_word_t. The latency is set by the shared one-bit-per-cycle sqrt/divide
// unit. One word is in work at a time; the result waits in the output register
// while out_ready is low, and a new input word is taken once that register is
// free or is being drained.
// Reset (rst_n low, synchronous) returns the sequencer to idle and empties
// the output register; memory contents are undefined until written.
// A stalled receiver simply holds the result; nothing is dropped.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mesh_face_normal_engine_core #(
  parameter int VERTEX_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mfne_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mfne_pkg::out_word_t out_data
);
  localparam int AW  = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam int FB  = 14;          // normal fraction bits
  localparam int NW  = FB + 2;
  localparam int DW  = FB + 31;     // dividend width
  localparam int ST  = 6;           // step counter width

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_RDP   = 12'b000000000010,
    S_DIFF  = 12'b000000000100,
    S_MUL   = 12'b000000001000,
    S_CROSS = 12'b000000010000,
    S_SHIFT = 12'b000000100000,
    S_SQ    = 12'b000001000000,
    S_SQRT  = 12'b000010000000,
    S_DIV   = 12'b000100000000,
    S_WR    = 12'b001000000000,
    S_RDN   = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  // memories
  logic [47:0] pos_mem [VERTEX_DEPTH];
  logic [47:0] nrm_mem [VERTEX_DEPTH];
  logic [47:0] pos_rd_r;
  logic [47:0] nrm_rd_r;
  logic        pos_we, nrm_we;
  logic [AW-1:0] pos_waddr, pos_raddr, nrm_addr;
  logic [47:0] pos_wdata;
  logic [47:0] nrm_wdata;

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
    pos_rd_r <= pos_mem[pos_raddr];
  end
  always_ff @(posedge clk) begin
    if (nrm_we) nrm_mem[nrm_addr] <= nrm_wdata;
    nrm_rd_r <= nrm_mem[nrm_addr];
  end

  mfne_pkg::in_word_t cmd_r;
  logic [1:0]  cnt_r;             // corner / component / write counter
  logic [2:0]  ok_r;              // corner in range
  logic signed [15:0] p_r [3][3]; // corner, axis
  logic signed [16:0] v1_r [3], v2_r [3];
  logic signed [33:0] pa_r [3], pb_r [3];
  logic [33:0] m_r [3];
  logic [2:0]  neg_r;
  logic [63:0] sum_r;
  logic [31:0] root_r;
  logic [65:0] rem_r;             // sqrt remainder / divide remainder
  logic [DW-1:0] quo_r;
  logic [ST-1:0] step_r;
  logic [30:0] len_r;
  logic signed [NW-1:0] n_r [3];
  logic        degen_r;
  logic        out_valid_r;
  mfne_pkg::out_word_t out_r;

  logic out_free;
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  logic acc;
  assign acc = in_valid && in_ready;

  function automatic logic in_rng(input logic [9:0] i);
    in_rng = ({22'd0, i} < VERTEX_DEPTH);
  endfunction

  logic [9:0] corner_sel;
  always_comb begin
    unique case (cnt_r)
      2'd0:    corner_sel = cmd_r.first_corner;
      2'd1:    corner_sel = cmd_r.middle_corner;
      default: corner_sel = cmd_r.last_corner;
    endcase
  end

  // write port control
  always_comb begin
    pos_we    = acc && in_data.command == mfne_pkg::CMD_WRITE_POS
                && in_rng(in_data.vertex_index);
    pos_waddr = AW'(in_data.vertex_index);
    pos_wdata = {in_data.pos_x, in_data.pos_y, in_data.pos_z};
    pos_raddr = AW'(corner_sel);
    nrm_we    = (state_r == S_WR) && in_rng(corner_sel);
    nrm_wdata = {n_r[0], n_r[1], n_r[2]};
    // hold the read address on the latched word once the read is under way
    if (state_r == S_WR)
      nrm_addr = AW'(corner_sel);
    else if (state_r == S_IDLE)
      nrm_addr = AW'(in_data.vertex_index);
    else
      nrm_addr = AW'(cmd_r.vertex_index);
  end

  // sqrt step: one result bit a cycle, 2 remainder bits
  logic [33:0] sq_trial;
  logic [65:0] sq_rem_sh;
  assign sq_rem_sh = {rem_r[63:0], sum_r[63:62]};
  assign sq_trial  = {root_r, 2'b01};
  // divide step
  logic [31:0] dv_rem_sh;
  assign dv_rem_sh = {rem_r[30:0], quo_r[DW-1]};

  // squares of the shifted magnitudes, full 60-bit products
  logic [59:0] sq_x, sq_y, sq_z;
  assign sq_x = m_r[0][29:0] * m_r[0][29:0];
  assign sq_y = m_r[1][29:0] * m_r[1][29:0];
  assign sq_z = m_r[2][29:0] * m_r[2][29:0];

  logic [33:0] mag;
  logic [33:0] mx;
  always_comb begin
    mx = (m_r[0] > m_r[1]) ? m_r[0] : m_r[1];
    if (m_r[2] > mx) mx = m_r[2];
    mag = m_r[cnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_ready) out_valid_r <= 1'b0;
      if (state_r == S_OUT) out_valid_r <= 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (acc && in_data.command == mfne_pkg::CMD_FACE) state_nxt = S_RDP;
               else if (acc && in_data.command == mfne_pkg::CMD_READ_NRM)
                 state_nxt = S_RDN;
      S_RDP:   if (cnt_r == 2'd3) state_nxt = S_DIFF;
      S_DIFF:  state_nxt = S_MUL;
      S_MUL:   state_nxt = S_CROSS;
      S_CROSS: state_nxt = S_SHIFT;
      S_SHIFT: if (mx[33:30] == 4'd0) state_nxt = (mx == 34'd0) ? S_WR : S_SQ;
      S_SQ:    state_nxt = S_SQRT;
      S_SQRT:  if (step_r == ST'(32)) state_nxt = S_DIV;
      S_DIV:   if (cnt_r == 2'd2 && step_r == ST'(DW)) state_nxt = S_WR;
      S_WR:    if (cnt_r == 2'd2) state_nxt = S_OUT;
      S_RDN:   state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        cmd_r   <= in_data;
        cnt_r   <= 2'd0;
        degen_r <= 1'b0;
      end
      S_RDP: begin
        // read issued for cnt_r, data for cnt_r-1 arrives now
        if (cnt_r != 2'd0) begin
          p_r[cnt_r-2'd1][0] <= ok_r[cnt_r-2'd1] ? pos_rd_r[47:32] : 16'sd0;
          p_r[cnt_r-2'd1][1] <= ok_r[cnt_r-2'd1] ? pos_rd_r[31:16] : 16'sd0;
          p_r[cnt_r-2'd1][2] <= ok_r[cnt_r-2'd1] ? pos_rd_r[15:0]  : 16'sd0;
        end
        if (cnt_r != 2'd3) ok_r[cnt_r] <= in_rng(corner_sel);
        cnt_r <= cnt_r + 2'd1;
      end
      S_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          v1_r[i] <= 17'(p_r[0][i]) - 17'(p_r[1][i]);
          v2_r[i] <= 17'(p_r[2][i]) - 17'(p_r[1][i]);
        end
      end
      S_MUL: begin
        pa_r[0] <= v2_r[1] * v1_r[2];  pb_r[0] <= v2_r[2] * v1_r[1];
        pa_r[1] <= v2_r[2] * v1_r[0];  pb_r[1] <= v2_r[0] * v1_r[2];
        pa_r[2] <= v2_r[0] * v1_r[1];  pb_r[2] <= v2_r[1] * v1_r[0];
      end
      S_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= pa_r[i] < pb_r[i];
          m_r[i]   <= (pa_r[i] < pb_r[i]) ? 34'(pb_r[i] - pa_r[i])
                                          : 34'(pa_r[i] - pb_r[i]);
        end
        cnt_r <= 2'd0;
      end
      S_SHIFT: begin
        if (mx[33:30] != 4'd0)
          for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
        if (mx == 34'd0) begin
          degen_r <= 1'b1;
          for (int i = 0; i < 3; i++) n_r[i] <= '0;
        end
        cnt_r <= 2'd0;
      end
      S_SQ: begin
        // three 30x30 squares side by side, sum stays below 2^62
        sum_r  <= 64'(sq_x) + 64'(sq_y) + 64'(sq_z);
        rem_r  <= '0;
        root_r <= '0;
        step_r <= '0;
      end
      S_SQRT: begin
        if (step_r != ST'(32)) begin
          sum_r <= {sum_r[61:0], 2'b00};
          if (sq_rem_sh >= 66'(sq_trial)) begin
            rem_r  <= sq_rem_sh - 66'(sq_trial);
            root_r <= {root_r[30:0], 1'b1};
          end else begin
            rem_r  <= sq_rem_sh;
            root_r <= {root_r[30:0], 1'b0};
          end
          step_r <= step_r + ST'(1);
        end else begin
          len_r  <= (root_r == 32'd0) ? 31'd1 : root_r[30:0];
          step_r <= '0;
          cnt_r  <= 2'd0;
        end
      end
      S_DIV: begin
        if (step_r == '0) begin
          quo_r  <= {1'b0, mag[29:0], {FB{1'b0}}};
          rem_r  <= '0;
          step_r <= ST'(1);
        end else if (step_r != ST'(DW)) begin
          if (dv_rem_sh >= {1'b0, len_r}) begin
            rem_r <= 66'(dv_rem_sh - {1'b0, len_r});
            quo_r <= {quo_r[DW-2:0], 1'b1};
          end else begin
            rem_r <= 66'(dv_rem_sh);
            quo_r <= {quo_r[DW-2:0], 1'b0};
          end
          step_r <= step_r + ST'(1);
        end else begin
          // quotient bits are shifted in; last step folds here
          logic [NW-1:0] q;
          q = (dv_rem_sh >= {1'b0, len_r}) ? NW'({quo_r[DW-2:0], 1'b1})
                                           : NW'({quo_r[DW-2:0], 1'b0});
          n_r[cnt_r] <= neg_r[cnt_r] ? -$signed(q) : $signed(q);
          step_r <= '0;
          cnt_r  <= (cnt_r == 2'd2) ? 2'd0 : cnt_r + 2'd1;
        end
      end
      S_WR: cnt_r <= cnt_r + 2'd1;
      default: ;
    endcase
    if (state_r == S_OUT && out_free) begin
      if (cmd_r.command == mfne_pkg::CMD_FACE) begin
        out_r.normal_x <= n_r[0];
        out_r.normal_y <= n_r[1];
        out_r.normal_z <= n_r[2];
      end else if (in_rng(cmd_r.vertex_index)) begin
        out_r.normal_x <= nrm_rd_r[47:32];
        out_r.normal_y <= nrm_rd_r[31:16];
        out_r.normal_z <= nrm_rd_r[15:0];
      end else begin
        out_r.normal_x <= '0;
        out_r.normal_y <= '0;
        out_r.normal_z <= '0;
      end
      out_r.degenerate <= (cmd_r.command == mfne_pkg::CMD_FACE) && degen_r;
      out_r.from_face  <= cmd_r.command == mfne_pkg::CMD_FACE;
    end
  end

  `ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready |-> state_r == S_IDLE,
               "input taken while busy")
  `ASSERT_IMPL(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid,
               "result dropped under stall")
  `ASSERT_IMPL(a_degen_zero, clk, rst_n,
               (out_valid && out_data.degenerate) |-> (out_data.normal_x == 16'sd0),
               "degenerate face with nonzero normal")
endmodule

[verif/mesh_face_normal_engine_core_tb.sv]
// Testbench for the mesh face normal engine: directed table plus random traffic.
`timescale 1ns / 1ps
module mesh_face_normal_engine_core_tb;

  localparam int DEPTH = 1024;
  localparam int FRAC = 14;
  localparam int CYCLE_LIMIT = 1200000;
  localparam int IN_W = $bits(mfne_pkg::in_word_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  mfne_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mfne_pkg::out_word_t out_data;

  mesh_face_normal_engine_core #(.VERTEX_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the vertex memories
  logic signed [15:0] pos_mem [DEPTH][3];
  logic signed [15:0] nrm_mem [DEPTH][3];
  bit pos_known [DEPTH];
  bit nrm_known [DEPTH];

  mfne_pkg::out_word_t normals_due[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  typedef struct {
    mfne_pkg::in_word_t word;
    bit fixed_exp;
    mfne_pkg::out_word_t exp_word;
  } row_t;

  function automatic logic [63:0] int_sqrt(logic [63:0] s);
    logic [63:0] res, bitv;
    res = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Updates the shadow memories; returns 1 when the word yields a result.
  function automatic bit compute_normal(mfne_pkg::in_word_t w,
                                        output mfne_pkg::out_word_t r);
    longint p[3][3];
    longint v1[3], v2[3], c[3];
    logic [63:0] a[3], m[3], mx, sum, len, q;
    int s;
    int idx[3];
    r = '0;
    idx[0] = int'(w.first_corner);
    idx[1] = int'(w.middle_corner);
    idx[2] = int'(w.last_corner);
    case (w.command)
      mfne_pkg::CMD_WRITE_POS: begin
        pos_mem[w.vertex_index][0] = w.pos_x;
        pos_mem[w.vertex_index][1] = w.pos_y;
        pos_mem[w.vertex_index][2] = w.pos_z;
        pos_known[w.vertex_index] = 1;
        return 0;
      end
      mfne_pkg::CMD_FACE: begin
        for (int k = 0; k < 3; k++)
          for (int j = 0; j < 3; j++) p[k][j] = longint'(pos_mem[idx[k]][j]);
        for (int j = 0; j < 3; j++) begin
          v1[j] = p[0][j] - p[1][j];
          v2[j] = p[2][j] - p[1][j];
        end
        c[0] = v2[1] * v1[2] - v2[2] * v1[1];
        c[1] = v2[2] * v1[0] - v2[0] * v1[2];
        c[2] = v2[0] * v1[1] - v2[1] * v1[0];
        mx = 64'd0;
        for (int j = 0; j < 3; j++) begin
          a[j] = (c[j] < 0) ? -c[j] : c[j];
          if (a[j] > mx) mx = a[j];
        end
        if (mx == 0) begin
          r.degenerate = 1'b1;
        end else begin
          s = 0;
          while ((mx >> s) >= (64'd1 << 30)) s++;
          sum = 64'd0;
          for (int j = 0; j < 3; j++) begin
            m[j] = a[j] >> s;
            sum += m[j] * m[j];
          end
          len = int_sqrt(sum);
          if (len == 0) len = 64'd1;
          q = (m[0] << FRAC) / len;
          r.normal_x = (c[0] < 0) ? -q[15:0] : q[15:0];
          q = (m[1] << FRAC) / len;
          r.normal_y = (c[1] < 0) ? -q[15:0] : q[15:0];
          q = (m[2] << FRAC) / len;
          r.normal_z = (c[2] < 0) ? -q[15:0] : q[15:0];
        end
        r.from_face = 1'b1;
        for (int k = 0; k < 3; k++) begin
          nrm_mem[idx[k]][0] = r.normal_x;
          nrm_mem[idx[k]][1] = r.normal_y;
          nrm_mem[idx[k]][2] = r.normal_z;
          nrm_known[idx[k]] = 1;
        end
        return 1;
      end
      mfne_pkg::CMD_READ_NRM: begin
        r.normal_x = nrm_mem[w.vertex_index][0];
        r.normal_y = nrm_mem[w.vertex_index][1];
        r.normal_z = nrm_mem[w.vertex_index][2];
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  task automatic send_word(mfne_pkg::in_word_t w);
    mfne_pkg::out_word_t r;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (compute_normal(w, r)) normals_due.push_back(r);
  endtask

  // Receiver
  always @(posedge clk) begin
    mfne_pkg::out_word_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (normals_due.size() == 0) begin
          $error("unexpected result word %h", out_data);
          errors++;
        end else begin
          e = normals_due.pop_front();
          if (out_data.normal_x !== e.normal_x) begin
            $error("normal_x exp %0d got %0d", e.normal_x, out_data.normal_x); errors++;
          end
          if (out_data.normal_y !== e.normal_y) begin
            $error("normal_y exp %0d got %0d", e.normal_y, out_data.normal_y); errors++;
          end
          if (out_data.normal_z !== e.normal_z) begin
            $error("normal_z exp %0d got %0d", e.normal_z, out_data.normal_z); errors++;
          end
          if (out_data.degenerate !== e.degenerate) begin
            $error("degenerate exp %0b got %0b", e.degenerate, out_data.degenerate); errors++;
          end
          if (out_data.from_face !== e.from_face) begin
            $error("from_face exp %0b got %0b", e.from_face, out_data.from_face); errors++;
          end
        end
      end
      out_ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic mfne_pkg::in_word_t pos_word(int vi, int x, int y, int z);
    mfne_pkg::in_word_t w;
    w = '0;
    w.command = mfne_pkg::CMD_WRITE_POS;
    w.vertex_index = 10'(vi);
    w.pos_x = 16'(x);
    w.pos_y = 16'(y);
    w.pos_z = 16'(z);
    return w;
  endfunction

  function automatic mfne_pkg::in_word_t face_word(int a, int b, int c);
    mfne_pkg::in_word_t w;
    w = '0;
    w.command = mfne_pkg::CMD_FACE;
    w.first_corner = 10'(a);
    w.middle_corner = 10'(b);
    w.last_corner = 10'(c);
    return w;
  endfunction

  function automatic mfne_pkg::in_word_t read_word(int vi);
    mfne_pkg::in_word_t w;
    w = '0;
    w.command = mfne_pkg::CMD_READ_NRM;
    w.vertex_index = 10'(vi);
    return w;
  endfunction

  function automatic mfne_pkg::out_word_t nrm(int x, int y, int z, bit dg, bit ff);
    mfne_pkg::out_word_t r;
    r.normal_x = 16'(x);
    r.normal_y = 16'(y);
    r.normal_z = 16'(z);
    r.degenerate = dg;
    r.from_face = ff;
    return r;
  endfunction

  // Random word; faces and reads only touch entries already written.
  function automatic mfne_pkg::in_word_t rand_word();
    mfne_pkg::in_word_t w;
    int k, v[3];
    int pool;
    w = IN_W'({$urandom, $urandom, $urandom});
    k = $urandom_range(99);
    pool = $urandom_range(1) ? 16 : DEPTH;
    if (k < 35) begin
      w.command = mfne_pkg::CMD_WRITE_POS;
      w.vertex_index = 10'($urandom_range(pool - 1));
      if ($urandom_range(3) == 0) begin
        w.pos_x = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        w.pos_y = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        w.pos_z = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      end
    end else if (k < 75) begin
      w.command = mfne_pkg::CMD_FACE;
      for (int j = 0; j < 3; j++) begin
        v[j] = $urandom_range(pool - 1);
        for (int t = 0; t < 50 && !pos_known[v[j]]; t++) v[j] = $urandom_range(pool - 1);
        if (!pos_known[v[j]]) v[j] = 0;
      end
      if ($urandom_range(9) == 0) v[2] = v[0];
      w.first_corner = 10'(v[0]);
      w.middle_corner = 10'(v[1]);
      w.last_corner = 10'(v[2]);
    end else if (k < 95) begin
      w.command = mfne_pkg::CMD_READ_NRM;
      v[0] = $urandom_range(pool - 1);
      for (int t = 0; t < 50 && !nrm_known[v[0]]; t++) v[0] = $urandom_range(pool - 1);
      if (!nrm_known[v[0]]) v[0] = 0;
      w.vertex_index = 10'(v[0]);
    end else begin
      w.command = mfne_pkg::CMD_NONE;
    end
    return w;
  endfunction

  initial begin
    row_t rows[$];
    int phase_idle[4] = '{0, 54, 0, 26};
    int phase_stall[4] = '{0, 0, 54, 26};
    int drain;
    rows.push_back('{pos_word(0, 0, 0, 0), 0, '0});
    rows.push_back('{pos_word(1, 16384, 0, 0), 0, '0});
    rows.push_back('{pos_word(2, 0, 16384, 0), 0, '0});
    // c = v2 x v1 points down z for this winding
    rows.push_back('{face_word(1, 0, 2), 1, nrm(0, 0, -16384, 0, 1)});
    rows.push_back('{read_word(0), 1, nrm(0, 0, -16384, 0, 0)});
    rows.push_back('{face_word(2, 0, 1), 1, nrm(0, 0, 16384, 0, 1)});
    rows.push_back('{read_word(2), 1, nrm(0, 0, 16384, 0, 0)});
    // collinear corners give a zero normal
    rows.push_back('{face_word(0, 0, 1), 1, nrm(0, 0, 0, 1, 1)});
    rows.push_back('{read_word(1), 1, nrm(0, 0, 0, 0, 0)});
    rows.push_back('{pos_word(1023, -32768, -32768, -32768), 0, '0});
    rows.push_back('{pos_word(3, 32767, 32767, 32767), 0, '0});
    rows.push_back('{pos_word(4, 32767, -32768, 32767), 0, '0});
    rows.push_back('{pos_word(5, -32768, 32767, -32768), 0, '0});
    rows.push_back('{face_word(1023, 3, 4), 0, '0});
    rows.push_back('{face_word(5, 1023, 3), 0, '0});
    rows.push_back('{read_word(1023), 0, '0});
    rows.push_back('{read_word(4), 0, '0});
    rows.push_back('{face_word(3, 4, 5), 0, '0});
    rows.push_back('{face_word(1023, 1023, 1023), 1, nrm(0, 0, 0, 1, 1)});
    rows.push_back('{read_word(1023), 1, nrm(0, 0, 0, 0, 0)});
    begin
      mfne_pkg::in_word_t w3;
      w3 = '1;
      w3.command = mfne_pkg::CMD_NONE;
      rows.push_back('{w3, 0, '0});
    end
    rows.push_back('{read_word(5), 0, '0});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    out_ready <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      send_word(rows[i].word);
      if (rows[i].fixed_exp) normals_due[normals_due.size() - 1] = rows[i].exp_word;
    end

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      repeat (475) send_word(rand_word());
    end
    in_valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;

    drain = 0;
    while (normals_due.size() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (400) @(posedge clk);
    if (errors == 0 && normals_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
